/* rtl/core/lz4fd_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lz4fd_pkg
// Types and constants shared by the frame deframer modules.
// ----------------------------------------------------------------------------
package lz4fd_pkg;

	localparam logic [31:0] MAGIC_WORD = 32'h184d2204;
	localparam logic [31:0] XP1 = 32'd2654435761;
	localparam logic [31:0] XP2 = 32'd2246822519;
	localparam logic [31:0] XP3 = 32'd3266489917;
	localparam logic [31:0] XP4 = 32'd668265263;
	localparam logic [31:0] XP5 = 32'd374761393;

	typedef enum logic [2:0] {
		EV_HDR_OK    = 3'd0,
		EV_BLK_START = 3'd1,
		EV_DATA      = 3'd2,
		EV_BLK_CHK   = 3'd3,
		EV_FRM_END   = 3'd4,
		EV_ERROR     = 3'd5
	} event_t;

	typedef enum logic [2:0] {
		ERR_MAGIC    = 3'd0,
		ERR_SIZECODE = 3'd1,
		ERR_DICT     = 3'd2,
		ERR_HDR_CHK  = 3'd3,
		ERR_TOO_BIG  = 3'd4
	} err_t;

	typedef enum logic [3:0] {
		PH_MAGIC, PH_FLG, PH_BD, PH_CSIZE, PH_HASH, PH_HC,
		PH_BSIZE, PH_DATA, PH_BCHK, PH_CCHK, PH_HALT
	} phase_t;

	// Hash sequencer control between parser and hash unit
	typedef struct packed {
		logic       start;
		logic [3:0] len;
	} hash_req_t;

	typedef struct packed {
		logic       done;
		logic [7:0] hc;
	} hash_rsp_t;

	typedef enum logic [3:0] {
		HS_IDLE, HS_W_ADD, HS_W_ROT, HS_B_ADD, HS_B_ROT,
		HS_F1, HS_F2, HS_F3, HS_F4, HS_F5
	} hstate_t;

endpackage
`default_nettype wire

/* rtl/core/lz4fd_hash.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lz4fd_hash
// XXH32 (seed 0) over the short frame descriptor, one shared 32x32 multiplier
// stepped by a small sequencer; returns hash bits 15:8.
// ----------------------------------------------------------------------------
module lz4fd_hash (
	input  wire                   clk,
	input  wire                   arst_n,
	input  lz4fd_pkg::hash_req_t  req,
	input  wire [79:0]            desc,
	output lz4fd_pkg::hash_rsp_t  rsp
);
	import lz4fd_pkg::*;

	hstate_t     st_q, st_d;
	logic [31:0] h_q, h_d;
	logic [3:0]  idx_q, idx_d;
	logic [3:0]  len_q;
	logic [31:0] mul_a, mul_b, prod;
	logic [31:0] word, rot17, rot11;
	logic [7:0]  bsel;

	// Select descriptor bytes at the cursor
	always_comb begin
		word = desc[{idx_q[3:0], 3'b000} +: 32];
		bsel = desc[{idx_q[3:0], 3'b000} +: 8];
	end
	assign rot17 = {h_q[14:0], h_q[31:15]};
	assign rot11 = {h_q[20:0], h_q[31:21]};

	// Shared multiplier operand selection
	always_comb begin
		mul_a = h_q;
		mul_b = XP2;
		case (st_q)
			HS_W_ADD: begin mul_a = word;        mul_b = XP3; end
			HS_W_ROT: begin mul_a = rot17;       mul_b = XP4; end
			HS_B_ADD: begin mul_a = {24'd0, bsel}; mul_b = XP5; end
			HS_B_ROT: begin mul_a = rot11;       mul_b = XP1; end
			HS_F2:    begin mul_a = h_q;         mul_b = XP2; end
			HS_F4:    begin mul_a = h_q;         mul_b = XP3; end
			default:  begin mul_a = h_q;         mul_b = XP2; end
		endcase
	end
	assign prod = mul_a * mul_b;

	// Next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			HS_IDLE:  if (req.start) st_d = (req.len >= 4'd4) ? HS_W_ADD :
				(req.len != 4'd0) ? HS_B_ADD : HS_F1;
			HS_W_ADD: st_d = HS_W_ROT;
			HS_W_ROT: st_d = (idx_q + 4'd8 <= len_q) ? HS_W_ADD :
				(idx_q + 4'd4 < len_q) ? HS_B_ADD : HS_F1;
			HS_B_ADD: st_d = HS_B_ROT;
			HS_B_ROT: st_d = (idx_q + 4'd1 < len_q) ? HS_B_ADD : HS_F1;
			HS_F1:    st_d = HS_F2;
			HS_F2:    st_d = HS_F3;
			HS_F3:    st_d = HS_F4;
			HS_F4:    st_d = HS_F5;
			HS_F5:    st_d = HS_IDLE;
			default:  st_d = HS_IDLE;
		endcase
	end

	// Datapath updates
	always_comb begin
		h_d = h_q;
		idx_d = idx_q;
		unique case (st_q)
			HS_IDLE:  begin h_d = XP5 + {28'd0, req.len}; idx_d = 4'd0; end
			HS_W_ADD: h_d = h_q + prod;
			HS_W_ROT: begin h_d = prod; idx_d = idx_q + 4'd4; end
			HS_B_ADD: h_d = h_q + prod;
			HS_B_ROT: begin h_d = prod; idx_d = idx_q + 4'd1; end
			HS_F1:    h_d = h_q ^ (h_q >> 15);
			HS_F2:    h_d = prod;
			HS_F3:    h_d = h_q ^ (h_q >> 13);
			HS_F4:    h_d = prod;
			HS_F5:    h_d = h_q ^ (h_q >> 16);
			default:  h_d = h_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= HS_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_ff @(posedge clk) begin
		h_q <= h_d;
		idx_q <= idx_d;
		if (st_q == HS_IDLE) len_q <= req.len;
	end

	// Outputs
	always_comb begin
		rsp.done = (st_q == HS_F5);
		rsp.hc   = h_d[15:8];
	end

	ap_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == HS_IDLE && req.start) |=> (st_q != HS_IDLE)) else $error("hash start lost");
	ap_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |=> !rsp.done) else $error("hash done repeated");
	ap_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == HS_B_ADD) |-> (idx_q < len_q)) else $error("hash index overrun");

endmodule
`default_nettype wire

/* rtl/core/lz4_frame_deframer.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lz4_frame_deframer
// LZ4 frame parser: magic, descriptor, header check, block sizes, payload
// pass-through, block and content checksums.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals
// in      | sink      | in_valid, in_ready, in_byte
// out     | source    | out_valid, out_ready, event_res .. error_code
//
// One byte per cycle in every phase except the header check byte: the hash
// sequencer holds the input low (longer for a descriptor with content size
// than for a two-byte descriptor) before that byte is taken.
// A result is valid in the output register the cycle after its byte is taken.
// No byte is taken while a result waits unaccepted; the register drains and
// refills in the same cycle. Reset clears all control state; after an error
// the input stays not ready until reset.
module lz4_frame_deframer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [7:0]  in_byte,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [2:0]  event_res,
	output logic [7:0]  data_byte,
	output logic [30:0] block_size,
	output logic        block_raw,
	output logic [22:0] max_block_size,
	output logic [63:0] frame_content_len,
	output logic [31:0] checksum_value,
	output logic        checksum_present,
	output logic        last_data,
	output logic [2:0]  error_code
);
	import lz4fd_pkg::*;

	phase_t      ph_q, ph_d;
	logic [1:0]  pos_q;
	logic [31:0] shift_q;
	logic [79:0] desc_q;
	logic [3:0]  dlen_q;
	logic        bchk_on_q, cchk_on_q, csize_on_q;
	logic [22:0] fmax_q;
	logic [30:0] rem_q;
	logic [7:0]  hc_q;
	hash_req_t   hreq;
	hash_rsp_t   hrsp;

	logic        acc, emit, slot_free;
	logic [31:0] word;
	logic [30:0] wsz;
	logic        too_big;
	logic [22:0] fmax_d;
	logic        msz_ok;

	lz4fd_hash u_hash (.clk(clk), .arst_n(arst_n), .req(hreq), .desc(desc_q), .rsp(hrsp));

	assign slot_free = !out_valid || out_ready;
	assign in_ready  = (ph_q != PH_HASH) && (ph_q != PH_HALT) && slot_free;
	assign acc       = in_valid && in_ready;
	assign word      = {in_byte, shift_q[23:0]};
	assign wsz       = word[30:0];
	assign too_big   = !word[31] && (wsz > {8'd0, fmax_q});

	// Decode maximum block size code
	always_comb begin
		msz_ok = 1'b1;
		case (in_byte[6:4])
			3'd4:    fmax_d = 23'd65536;
			3'd5:    fmax_d = 23'd262144;
			3'd6:    fmax_d = 23'd1048576;
			3'd7:    fmax_d = 23'd4194304;
			default: begin fmax_d = 23'd0; msz_ok = 1'b0; end
		endcase
	end

	// Next phase
	always_comb begin
		ph_d = ph_q;
		if (acc) begin
			unique case (ph_q)
				PH_MAGIC: if (pos_q == 2'd3) ph_d = (word == MAGIC_WORD) ? PH_FLG : PH_HALT;
				PH_FLG:   ph_d = PH_BD;
				PH_BD:    ph_d = !msz_ok ? PH_HALT : csize_on_q ? PH_CSIZE :
					desc_q[0] ? PH_HALT : PH_HASH;
				PH_CSIZE: if (dlen_q == 4'd9) ph_d = desc_q[0] ? PH_HALT : PH_HASH;
				PH_HC:    ph_d = (hc_q == in_byte) ? PH_BSIZE : PH_HALT;
				PH_BSIZE: if (pos_q == 2'd3) begin
					if (too_big) ph_d = PH_HALT;
					else if (wsz == 31'd0) ph_d = cchk_on_q ? PH_CCHK : PH_MAGIC;
					else ph_d = PH_DATA;
				end
				PH_DATA:  if (rem_q <= 31'd1) ph_d = bchk_on_q ? PH_BCHK : PH_BSIZE;
				PH_BCHK:  if (pos_q == 2'd3) ph_d = PH_BSIZE;
				PH_CCHK:  if (pos_q == 2'd3) ph_d = PH_MAGIC;
				default:  ph_d = ph_q;
			endcase
		end else if (ph_q == PH_HASH && hrsp.done) begin
			ph_d = PH_HC;
		end
	end

	// Hash request
	always_comb begin
		hreq.start = (ph_q == PH_HASH);
		hreq.len   = dlen_q;
	end

	// Result generation
	always_comb begin
		emit = 1'b0;
		if (acc) begin
			case (ph_q)
				PH_MAGIC: emit = (pos_q == 2'd3) && (word != MAGIC_WORD);
				PH_BD:    emit = !msz_ok || (!csize_on_q && desc_q[0]);
				PH_CSIZE: emit = (dlen_q == 4'd9) && desc_q[0];
				PH_HC, PH_DATA: emit = 1'b1;
				PH_BSIZE: emit = (pos_q == 2'd3) &&
					!(wsz == 31'd0 && cchk_on_q && !too_big);
				PH_BCHK, PH_CCHK: emit = (pos_q == 2'd3);
				default:  emit = 1'b0;
			endcase
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_MAGIC;
			pos_q <= 2'd0;
			shift_q <= 32'd0;
			dlen_q <= 4'd0;
			bchk_on_q <= 1'b0;
			cchk_on_q <= 1'b0;
			csize_on_q <= 1'b0;
			fmax_q <= 23'd0;
			rem_q <= 31'd0;
			out_valid <= 1'b0;
		end else begin
			ph_q <= ph_d;
			if (emit) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			if (acc) begin
				// Gather little-endian words
				if (ph_q == PH_MAGIC || ph_q == PH_BSIZE || ph_q == PH_BCHK ||
				    ph_q == PH_CCHK) begin
					pos_q <= pos_q + 2'd1;
					if (pos_q == 2'd3) shift_q <= 32'd0;
					else shift_q[{pos_q, 3'b000} +: 8] <= in_byte;
				end
				case (ph_q)
					PH_FLG: begin
						dlen_q <= 4'd1;
						bchk_on_q <= in_byte[4];
						cchk_on_q <= in_byte[2];
						csize_on_q <= in_byte[3];
					end
					PH_BD: begin
						dlen_q <= 4'd2;
						fmax_q <= fmax_d;
					end
					PH_CSIZE: dlen_q <= dlen_q + 4'd1;
					PH_HC: begin
						pos_q <= 2'd0;
						shift_q <= 32'd0;
					end
					PH_BSIZE: if (pos_q == 2'd3) begin
						rem_q <= wsz;
					end
					PH_DATA: rem_q <= (rem_q <= 31'd1) ? 31'd0 : rem_q - 31'd1;
					default: ;
				endcase
			end
		end
	end

	// Descriptor store and header check latch
	always_ff @(posedge clk) begin
		if (acc && ph_q == PH_FLG) desc_q[7:0] <= in_byte;
		if (acc && ph_q == PH_BD) desc_q[15:8] <= in_byte;
		if (acc && ph_q == PH_CSIZE) desc_q[{dlen_q, 3'b000} +: 8] <= in_byte;
		if (ph_q == PH_HASH && hrsp.done) hc_q <= hrsp.hc;
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (emit) begin
			event_res <= EV_ERROR;
			data_byte <= 8'd0;
			block_size <= 31'd0;
			block_raw <= 1'b0;
			max_block_size <= 23'd0;
			frame_content_len <= 64'd0;
			checksum_value <= 32'd0;
			checksum_present <= 1'b0;
			last_data <= 1'b0;
			error_code <= ERR_MAGIC;
			case (ph_q)
				PH_MAGIC: error_code <= ERR_MAGIC;
				PH_BD:    error_code <= msz_ok ? ERR_DICT : ERR_SIZECODE;
				PH_CSIZE: error_code <= ERR_DICT;
				PH_HC: if (hc_q != in_byte) begin
					error_code <= ERR_HDR_CHK;
				end else begin
					event_res <= EV_HDR_OK;
					max_block_size <= fmax_q;
					frame_content_len <= csize_on_q ? desc_q[79:16] : 64'd0;
				end
				PH_BSIZE: if (too_big) begin
					error_code <= ERR_TOO_BIG;
				end else if (wsz == 31'd0) begin
					event_res <= EV_FRM_END;
				end else begin
					event_res <= EV_BLK_START;
					block_size <= wsz;
					block_raw <= word[31];
				end
				PH_DATA: begin
					event_res <= EV_DATA;
					data_byte <= in_byte;
					last_data <= (rem_q <= 31'd1);
				end
				PH_BCHK: begin
					event_res <= EV_BLK_CHK;
					checksum_value <= word;
				end
				PH_CCHK: begin
					event_res <= EV_FRM_END;
					checksum_value <= word;
					checksum_present <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	ap_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_HALT) |=> (ph_q == PH_HALT)) else $error("left halt");
	ap_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !emit) else $error("result overwritten");
	ap_hash_no_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_HASH) |-> !acc) else $error("byte taken during hash");
	ap_data_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(ph_q == PH_DATA) |-> (rem_q != 31'd0)) else $error("empty data phase");

endmodule
`default_nettype wire

/* bench/lz4_frame_monitor.sv */
// ----------------------------------------------------------------------------
// lz4_frame_monitor
// Watches both channels of the frame deframer, tracks the frame grammar
// from every accepted request byte, and compares each result with the
// oldest predicted event, field by field.
// ----------------------------------------------------------------------------
module lz4_frame_monitor (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_ready,
	input  wire  [7:0]  in_byte,
	input  wire         out_valid,
	input  wire         out_ready,
	input  wire  [2:0]  event_res,
	input  wire  [7:0]  data_byte,
	input  wire  [30:0] block_size,
	input  wire         block_raw,
	input  wire  [22:0] max_block_size,
	input  wire  [63:0] frame_content_len,
	input  wire  [31:0] checksum_value,
	input  wire         checksum_present,
	input  wire         last_data,
	input  wire  [2:0]  error_code,
	output int          fail_count,
	output int          pending_events
);
	import lz4fd_pkg::*;

	typedef struct packed {
		logic [2:0]  ev;
		logic [7:0]  data;
		logic [30:0] bsize;
		logic        raw;
		logic [22:0] maxb;
		logic [63:0] csize;
		logic [31:0] chk;
		logic        chk_on;
		logic        last;
		logic [2:0]  err;
	} frame_event_t;

	frame_event_t event_q[$];

	// parser state mirror
	phase_t      ph;
	int          pos;
	logic [63:0] shift;
	logic [7:0]  desc [10];
	int          desc_len;
	logic        bchk_on, cchk_on, csize_on, cur_raw;
	logic [22:0] max_size;
	logic [30:0] remaining;

	assign pending_events = event_q.size();

	function automatic logic [31:0] rotl(input logic [31:0] v, input int r);
		return (v << r) | (v >> (32 - r));
	endfunction

	// header check byte: bits 15:8 of the short-input XXH32
	function automatic logic [7:0] header_check(input int len);
		logic [31:0] h;
		logic [31:0] w;
		int i;
		h = XP5 + len;
		i = 0;
		while (i + 4 <= len) begin
			w = {desc[i+3], desc[i+2], desc[i+1], desc[i]};
			h = h + w * XP3;
			h = rotl(h, 17) * XP4;
			i += 4;
		end
		while (i < len) begin
			h = h + {24'd0, desc[i]} * XP5;
			h = rotl(h, 11) * XP1;
			i++;
		end
		h ^= h >> 15;
		h = h * XP2;
		h ^= h >> 13;
		h = h * XP3;
		h ^= h >> 16;
		return h[15:8];
	endfunction

	function automatic frame_event_t blank_event(input event_t e);
		frame_event_t r;
		r = '0;
		r.ev = e;
		return r;
	endfunction

	task automatic push_error(input err_t code);
		frame_event_t r;
		r = blank_event(EV_ERROR);
		r.err = code;
		event_q.push_back(r);
		ph = PH_HALT;
	endtask

	// advance the grammar by one request byte
	task automatic parse_byte(input logic [7:0] b);
		frame_event_t r;
		logic [31:0] w;
		logic [2:0] code;
		case (ph)
			PH_MAGIC: begin
				shift[8*pos +: 8] = b;
				pos++;
				if (pos == 4) begin
					w = shift[31:0];
					pos = 0; shift = '0;
					if (w != MAGIC_WORD) push_error(ERR_MAGIC);
					else ph = PH_FLG;
				end
			end
			PH_FLG: begin
				desc[0] = b; desc_len = 1;
				bchk_on = b[4]; cchk_on = b[2]; csize_on = b[3];
				ph = PH_BD;
			end
			PH_BD: begin
				desc[1] = b; desc_len = 2;
				code = b[6:4];
				case (code)
					3'd4: max_size = 23'd65536;
					3'd5: max_size = 23'd262144;
					3'd6: max_size = 23'd1048576;
					3'd7: max_size = 23'd4194304;
					default: ;
				endcase
				if (code < 3'd4) push_error(ERR_SIZECODE);
				else if (csize_on) ph = PH_CSIZE;
				else if (desc[0][0]) push_error(ERR_DICT);
				else ph = PH_HC;
			end
			PH_CSIZE: begin
				desc[desc_len] = b;
				desc_len++;
				if (desc_len == 10) begin
					if (desc[0][0]) push_error(ERR_DICT);
					else ph = PH_HC;
				end
			end
			PH_HC: begin
				if (header_check(desc_len) != b) push_error(ERR_HDR_CHK);
				else begin
					r = blank_event(EV_HDR_OK);
					r.maxb = max_size;
					if (csize_on)
						for (int i = 0; i < 8; i++) r.csize[8*i +: 8] = desc[2+i];
					event_q.push_back(r);
					pos = 0; shift = '0;
					ph = PH_BSIZE;
				end
			end
			PH_BSIZE: begin
				shift[8*pos +: 8] = b;
				pos++;
				if (pos == 4) begin
					w = shift[31:0];
					pos = 0; shift = '0;
					cur_raw = w[31];
					w[31] = 1'b0;
					if (!cur_raw && w > {9'd0, max_size}) push_error(ERR_TOO_BIG);
					else if (w == 0) begin
						if (cchk_on) ph = PH_CCHK;
						else begin
							event_q.push_back(blank_event(EV_FRM_END));
							ph = PH_MAGIC;
						end
					end else begin
						remaining = w[30:0];
						r = blank_event(EV_BLK_START);
						r.bsize = w[30:0];
						r.raw = cur_raw;
						event_q.push_back(r);
						ph = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				r = blank_event(EV_DATA);
				r.data = b;
				if (remaining <= 1) begin
					remaining = 0;
					r.last = 1'b1;
					pos = 0; shift = '0;
					ph = bchk_on ? PH_BCHK : PH_BSIZE;
				end else begin
					remaining--;
				end
				event_q.push_back(r);
			end
			PH_BCHK, PH_CCHK: begin
				shift[8*pos +: 8] = b;
				pos++;
				if (pos == 4) begin
					r = blank_event(ph == PH_BCHK ? EV_BLK_CHK : EV_FRM_END);
					r.chk = shift[31:0];
					r.chk_on = (ph == PH_CCHK);
					event_q.push_back(r);
					pos = 0; shift = '0;
					ph = (ph == PH_BCHK) ? PH_BSIZE : PH_MAGIC;
				end
			end
			default: ;
		endcase
	endtask

	// compare one result with the oldest prediction
	task automatic check_result();
		frame_event_t got, exp_ev;
		got = '{event_res, data_byte, block_size, block_raw, max_block_size,
			frame_content_len, checksum_value, checksum_present, last_data, error_code};
		if (event_q.size() == 0) begin
			$display("%0t: unexpected result, actual %p", $realtime, got);
			fail_count++;
		end else begin
			exp_ev = event_q.pop_front();
			if (got != exp_ev) begin
				$display("%0t: mismatch, expected %p, actual %p", $realtime, exp_ev, got);
				fail_count++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count = 0;
			ph = PH_MAGIC; pos = 0; shift = '0; desc_len = 0;
			bchk_on = 0; cchk_on = 0; csize_on = 0; cur_raw = 0;
			max_size = '0; remaining = '0;
			event_q.delete();
		end else begin
			if (out_valid && out_ready) check_result();
			if (in_valid && in_ready) parse_byte(in_byte);
		end
	end

endmodule

/* bench/tb_lz4_frame_deframer.sv */
// ----------------------------------------------------------------------------
// tb_lz4_frame_deframer
// Feeds the frame deframer well-formed LZ4 frames with random flags, sizes
// and payloads under random stalls on both sides, and ends the run with
// an error frame; the monitor does the checking.
// ----------------------------------------------------------------------------
module tb_lz4_frame_deframer;
	import lz4fd_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_res;
	logic [7:0]  data_byte;
	logic [30:0] block_size;
	logic        block_raw;
	logic [22:0] max_block_size;
	logic [63:0] frame_content_len;
	logic [31:0] checksum_value;
	logic        checksum_present;
	logic        last_data;
	logic [2:0]  error_code;
	int          fail_count;
	int          pending_events;
	logic        calm = 1'b0;
	logic        hold_off = 1'b0;
	int          sent = 0;
	logic [7:0]  frame_q[$];

	lz4_frame_deframer uut (.*);

	lz4_frame_monitor monitor (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, plus one long hold-off
	always @(posedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else out_ready <= calm || ($urandom_range(99) >= 11);
	end

	initial begin
		wait (sent > 60);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	// short XXH32 for building valid header check bytes
	function automatic logic [7:0] hc_of(input logic [7:0] d [10], input int len);
		logic [31:0] h;
		int i;
		h = XP5 + len;
		i = 0;
		while (i + 4 <= len) begin
			h = h + {d[i+3], d[i+2], d[i+1], d[i]} * XP3;
			h = ((h << 17) | (h >> 15)) * XP4;
			i += 4;
		end
		while (i < len) begin
			h = h + {24'd0, d[i]} * XP5;
			h = ((h << 11) | (h >> 21)) * XP1;
			i++;
		end
		h ^= h >> 15; h = h * XP2; h ^= h >> 13; h = h * XP3; h ^= h >> 16;
		return h[15:8];
	endfunction

	task automatic push_word(input logic [31:0] w);
		for (int i = 0; i < 4; i++) frame_q.push_back(w[8*i +: 8]);
	endtask

	// queue one frame; corrupt picks a header fault (0 = none)
	task automatic build_frame(input logic [7:0] flg, input logic [2:0] code,
			input int nblocks, input int corrupt, input logic [31:0] bad_size);
		logic [7:0] d [10];
		int len, n;
		logic raw;
		logic [7:0] hc;
		d = '{default: 8'h00};
		push_word(corrupt == 1 ? MAGIC_WORD ^ (32'd1 << $urandom_range(31))
			: MAGIC_WORD);
		d[0] = flg;
		d[1] = {$urandom_range(1) == 1, code, 4'($urandom)};
		len = 2;
		if (flg[3]) begin
			for (int i = 2; i < 10; i++) d[i] = 8'($urandom);
			len = 10;
		end
		for (int i = 0; i < len; i++) frame_q.push_back(d[i]);
		hc = hc_of(d, len);
		frame_q.push_back(corrupt == 2 ? hc ^ 8'(1 << $urandom_range(7)) : hc);
		if (bad_size != 0) push_word(bad_size);
		for (int k = 0; k < nblocks; k++) begin
			n = ($urandom_range(9) == 0) ? $urandom_range(60) : $urandom_range(1, 12);
			raw = $urandom_range(1);
			if (n == 0) n = 1;
			push_word({raw, 31'(n)});
			for (int i = 0; i < n; i++) frame_q.push_back(8'($urandom));
			if (flg[4]) push_word($urandom);
		end
		push_word($urandom_range(1) ? 32'h80000000 : 32'h0);
		if (flg[2]) push_word($urandom);
	endtask

	function automatic logic [7:0] rand_flg();
		return {2'($urandom), 1'b1, 4'($urandom) & 4'b1110 | 4'($urandom) & 4'b0010,
			1'b0} | {2'b00, 1'b0, 1'($urandom), 1'($urandom), 1'($urandom), 2'b00};
	endfunction

	initial begin
		logic [7:0] b;
		int stall;
		stall = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// directed: all four valid size codes and flag mixes; end words are random
		build_frame(8'h40, 3'd4, 1, 0, 0);
		build_frame(8'hFE, 3'd7, 2, 0, 0);
		build_frame(8'h0C, 3'd5, 1, 0, 0);
		build_frame(8'h50, 3'd6, 1, 0, 0);
		for (int f = 0; f < 16; f++)
			build_frame(rand_flg(), 3'($urandom_range(4, 7)), $urandom_range(0, 3), 0, 0);
		calm <= 1'b0;
		while (frame_q.size() > 0) begin
			b = frame_q.pop_front();
			in_valid <= 1'b1;
			in_byte <= b;
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			sent++;
			calm <= (sent > 400 && sent < 700);
			if (!calm && $urandom_range(99) < 11) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		// one fatal header or block size fault, then bytes that the halted block refuses
		case ($urandom_range(4))
			0: build_frame(8'h40, 3'd4, 0, 1, 0);
			1: build_frame(8'h40, 3'($urandom_range(3)), 0, 0, 0);
			2: build_frame(8'h41, 3'd4, 0, 0, 0);
			3: build_frame(8'h40, 3'd4, 0, 2, 0);
			default: build_frame(8'h40, 3'd4, 0, 0, 32'h00010001);
		endcase
		for (int i = 0; i < 20; i++) frame_q.push_back(8'($urandom));
		while (frame_q.size() > 0 && stall < 200) begin
			in_valid <= 1'b1;
			in_byte <= frame_q.pop_front();
			@(posedge clk);
			stall = 0;
			while (!in_ready && stall < 200) begin
				@(posedge clk);
				stall++;
			end
		end
		wait (pending_events == 0);
		repeat (40) @(posedge clk);
		if (fail_count == 0) $display("Verification passed");
		else $display("Verification failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Verification failed");
		$finish;
	end

endmodule
